>>> design/sel_lex_pkg.sv
// Shared types, token codes and character helpers for the selector lexer.
`timescale 1ns / 1ps
`default_nettype none
package sel_lex_pkg;

  localparam int PositionBitsDefault = 16;
  localparam int KeywordCharsDefault = 7;
  localparam int QueueDepth = 4;

  localparam logic [4:0] K_END    = 5'd0;
  localparam logic [4:0] K_LPAREN = 5'd1;
  localparam logic [4:0] K_RPAREN = 5'd2;
  localparam logic [4:0] K_COMMA  = 5'd3;
  localparam logic [4:0] K_PLUS   = 5'd4;
  localparam logic [4:0] K_MINUS  = 5'd5;
  localparam logic [4:0] K_STAR   = 5'd6;
  localparam logic [4:0] K_SLASH  = 5'd7;
  localparam logic [4:0] K_EQUAL  = 5'd8;
  localparam logic [4:0] K_LESS   = 5'd9;
  localparam logic [4:0] K_NEQ    = 5'd10;
  localparam logic [4:0] K_LSEQ   = 5'd11;
  localparam logic [4:0] K_GRT    = 5'd12;
  localparam logic [4:0] K_GREQ   = 5'd13;
  localparam logic [4:0] K_IDENT  = 5'd14;
  localparam logic [4:0] K_STRING = 5'd15;
  localparam logic [4:0] K_EXACT  = 5'd16;
  localparam logic [4:0] K_APPROX = 5'd17;
  localparam logic [4:0] K_WORD0  = 5'd18;
  localparam logic [4:0] K_ERROR  = 5'd29;

  // Lexer states, one-hot.
  typedef enum logic [18:0] {
    S_START     = 19'h00001,
    S_ERROR     = 19'h00002,
    S_LT        = 19'h00004,
    S_GT        = 19'h00008,
    S_IDENT     = 19'h00010,
    S_QUOTED    = 19'h00020,
    S_QCLOSE    = 19'h00040,
    S_ZERO      = 19'h00080,
    S_DIGIT     = 19'h00100,
    S_HEX_START = 19'h00200,
    S_HEX       = 19'h00400,
    S_OCT       = 19'h00800,
    S_BIN_START = 19'h01000,
    S_BIN       = 19'h02000,
    S_DEC_START = 19'h04000,
    S_DEC       = 19'h08000,
    S_EXP_SIGN  = 19'h10000,
    S_EXP_START = 19'h20000,
    S_EXP       = 19'h40000
  } lex_state_t;

  // One input item after classification, as it waits in the queue.
  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
    logic       is_digit;
    logic       is_alpha;
    logic       is_xdigit;
    logic       is_space;
    logic [7:0] lower_code;
  } char_item_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    if (c inside {[8'h41:8'h5A]}) begin
      return c + 8'd32;
    end
    return c;
  endfunction

  // Keyword characters, lowercase, padded with zeros to eight.
  function automatic logic [63:0] word_text(input logic [3:0] i);
    case (i)
      4'd0:  return {40'd0, "dna"};
      4'd1:  return {8'd0, "neewteb"};
      4'd2:  return {16'd0, "epacse"};
      4'd3:  return {24'd0, "eslaf"};
      4'd4:  return {48'd0, "ni"};
      4'd5:  return {48'd0, "si"};
      4'd6:  return {32'd0, "ekil"};
      4'd7:  return {40'd0, "ton"};
      4'd8:  return {32'd0, "llun"};
      4'd9:  return {48'd0, "ro"};
      4'd10: return {32'd0, "eurt"};
      default: return 64'd0;
    endcase
  endfunction

  function automatic logic [3:0] word_len(input logic [3:0] i);
    case (i)
      4'd0: return 4'd3;
      4'd1: return 4'd7;
      4'd2: return 4'd6;
      4'd3: return 4'd5;
      4'd4: return 4'd2;
      4'd5: return 4'd2;
      4'd6: return 4'd4;
      4'd7: return 4'd3;
      4'd8: return 4'd4;
      4'd9: return 4'd2;
      4'd10: return 4'd4;
      default: return 4'd0;
    endcase
  endfunction

endpackage
`default_nettype wire

>>> design/sel_lex_front.sv
// Front end: takes characters, classifies them and queues them for the lexer core.
`timescale 1ns / 1ps
`default_nettype none
module sel_lex_front (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [7:0]              char_code,
  input  wire logic                    end_of_text,
  output logic                         q_valid,
  input  wire logic                    q_ready,
  output sel_lex_pkg::char_item_t      q_item
);

  localparam int AW = $clog2(sel_lex_pkg::QueueDepth);

  sel_lex_pkg::char_item_t mem [sel_lex_pkg::QueueDepth];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          push;
  logic          pop;
  sel_lex_pkg::char_item_t item;

  always_comb begin
    item.char_code   = char_code;
    item.end_of_text = end_of_text;
    item.is_digit    = char_code inside {[8'h30:8'h39]};
    item.is_alpha    = (char_code inside {[8'h41:8'h5A]}) || (char_code inside {[8'h61:8'h7A]});
    item.is_xdigit   = item.is_digit || (char_code inside {[8'h41:8'h46]})
                       || (char_code inside {[8'h61:8'h66]});
    item.is_space    = (char_code == 8'h20) || (char_code inside {[8'd9:8'd13]});
    item.lower_code  = sel_lex_pkg::to_lower(char_code);
  end

  assign in_ready = (count != (AW+1)'(sel_lex_pkg::QueueDepth));
  assign q_valid  = (count != '0);
  assign q_item   = mem[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule
`default_nettype wire

>>> design/sel_lex_core.sv
// Lexer core: state machine, keyword match and a two-token output buffer.
`timescale 1ns / 1ps
`default_nettype none
module sel_lex_core #(
  parameter int PositionBits = sel_lex_pkg::PositionBitsDefault,
  parameter int KeywordChars = sel_lex_pkg::KeywordCharsDefault
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    q_valid,
  output logic                         q_ready,
  input  wire sel_lex_pkg::char_item_t q_item,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [4:0]                   token_kind,
  output logic [15:0]                  token_offset,
  output logic [15:0]                  token_length,
  output logic                         last_of_run
);

  localparam int KW = $clog2(KeywordChars);

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] offset;
    logic [15:0] length;
  } token_t;

  sel_lex_pkg::lex_state_t state, state_next;
  logic [PositionBits-1:0] char_position, char_position_next;
  logic [PositionBits-1:0] token_begin, token_begin_next;
  logic [4:0]              pending_kind, pending_kind_next;
  logic [7:0]              word_buffer [KeywordChars];
  logic                    word_too_long, word_too_long_next;
  logic                    quote_is_double, quote_is_double_next;
  logic                    wb_we0, wb_we;
  logic [KW-1:0]           wb_idx;

  // Output buffer: up to two tokens from one character.
  token_t      buf0, buf1;
  logic [1:0]  buf_cnt;
  logic        buf1_last;

  token_t      t0, t1;
  logic [1:0]  n_tok;

  logic [7:0]  c, lc;
  logic        step;
  logic [PositionBits-1:0] p, span;
  logic [4:0]  word_k;
  logic        ident_ch, qch, fd;

  assign c  = q_item.char_code;
  assign lc = q_item.lower_code;
  assign p  = char_position;
  assign span = p - token_begin;
  assign fd = (lc == "f") || (lc == "d");
  assign ident_ch = q_item.is_alpha || q_item.is_digit || (c == "_") || (c == "$")
                    || (c == ".");
  assign qch = quote_is_double ? (c == 8'h22) : (c == 8'h27);

  assign q_ready = (buf_cnt == 2'd0) || ((buf_cnt == 2'd1) && out_ready);
  assign step    = q_valid && q_ready;

  // Keyword compare against the buffered word, lowercased, of length span.
  always_comb begin
    logic        hit;
    logic [63:0] wt;
    word_k = sel_lex_pkg::K_IDENT;
    for (int i = 10; i >= 0; i--) begin
      hit = !word_too_long && (span == PositionBits'(sel_lex_pkg::word_len(4'(i))));
      wt  = sel_lex_pkg::word_text(4'(i));
      for (int j = 0; j < 7; j++) begin
        if (j < int'(sel_lex_pkg::word_len(4'(i)))) begin
          if (sel_lex_pkg::to_lower(word_buffer[j]) != wt[8*j +: 8]) begin
            hit = 1'b0;
          end
        end
      end
      if (hit) begin
        word_k = sel_lex_pkg::K_WORD0 + 5'(i);
      end
    end
  end

  always_comb begin
    sel_lex_pkg::lex_state_t st;
    logic close_with, close_wo, failed, restart;
    logic [4:0] ck;
    state_next           = state;
    char_position_next   = p + 1'b1;
    token_begin_next     = token_begin;
    pending_kind_next    = pending_kind;
    word_too_long_next   = word_too_long;
    quote_is_double_next = quote_is_double;
    wb_we0 = 1'b0;
    wb_we  = 1'b0;
    wb_idx = span[KW-1:0];
    t0 = '0;
    t1 = '0;
    n_tok = 2'd0;
    close_with = 1'b0;
    close_wo   = 1'b0;
    failed     = 1'b0;
    restart    = 1'b0;
    ck = sel_lex_pkg::K_EXACT;
    st = state;

    if (q_item.end_of_text) begin
      n_tok = 2'd1;
      t0 = '{kind: sel_lex_pkg::K_END, offset: 16'(p), length: 16'd0};
      t1 = t0;
      case (state)
        sel_lex_pkg::S_LT: ck = sel_lex_pkg::K_LESS;
        sel_lex_pkg::S_GT: ck = sel_lex_pkg::K_GRT;
        sel_lex_pkg::S_IDENT: ck = word_k;
        sel_lex_pkg::S_QCLOSE: ck = pending_kind;
        sel_lex_pkg::S_ZERO, sel_lex_pkg::S_DIGIT, sel_lex_pkg::S_HEX, sel_lex_pkg::S_BIN,
        sel_lex_pkg::S_OCT: ck = sel_lex_pkg::K_EXACT;
        sel_lex_pkg::S_DEC, sel_lex_pkg::S_EXP: ck = sel_lex_pkg::K_APPROX;
        default: ck = sel_lex_pkg::K_ERROR;
      endcase
      if (!(state == sel_lex_pkg::S_START || state == sel_lex_pkg::S_ERROR)) begin
        n_tok = 2'd2;
        t0 = '{kind: ck, offset: 16'(token_begin), length: 16'(span)};
      end
      state_next           = sel_lex_pkg::S_START;
      char_position_next   = '0;
      token_begin_next     = '0;
      pending_kind_next    = '0;
      word_too_long_next   = 1'b0;
      quote_is_double_next = 1'b0;
    end else begin
      if (state == sel_lex_pkg::S_ZERO) begin
        if (c == ".") st = sel_lex_pkg::S_DEC;
        else if (lc == "x") st = sel_lex_pkg::S_HEX_START;
        else if (lc == "b") st = sel_lex_pkg::S_BIN_START;
        else st = sel_lex_pkg::S_OCT;
      end
      state_next = st;
      if (state != sel_lex_pkg::S_ZERO || st == sel_lex_pkg::S_OCT) begin
        case (st)
          sel_lex_pkg::S_START: restart = 1'b1;
          sel_lex_pkg::S_ERROR: ;
          sel_lex_pkg::S_LT: begin
            if (c == ">") begin close_with = 1'b1; ck = sel_lex_pkg::K_NEQ; end
            else if (c == "=") begin close_with = 1'b1; ck = sel_lex_pkg::K_LSEQ; end
            else begin close_wo = 1'b1; ck = sel_lex_pkg::K_LESS; end
          end
          sel_lex_pkg::S_GT: begin
            if (c == "=") begin close_with = 1'b1; ck = sel_lex_pkg::K_GREQ; end
            else begin close_wo = 1'b1; ck = sel_lex_pkg::K_GRT; end
          end
          sel_lex_pkg::S_IDENT: begin
            if (ident_ch) begin
              if (span < PositionBits'(KeywordChars)) wb_we = 1'b1;
              else word_too_long_next = 1'b1;
            end else begin
              close_wo = 1'b1;
              ck = word_k;
            end
          end
          sel_lex_pkg::S_QUOTED: if (qch) state_next = sel_lex_pkg::S_QCLOSE;
          sel_lex_pkg::S_QCLOSE: begin
            if (qch) state_next = sel_lex_pkg::S_QUOTED;
            else begin close_wo = 1'b1; ck = pending_kind; end
          end
          sel_lex_pkg::S_HEX_START: begin
            if (q_item.is_xdigit) state_next = sel_lex_pkg::S_HEX; else failed = 1'b1;
          end
          sel_lex_pkg::S_HEX: begin
            if (lc == "l") close_with = 1'b1;
            else if (q_item.is_xdigit || c == "_") ;
            else if (lc == "p") state_next = sel_lex_pkg::S_EXP_SIGN;
            else close_wo = 1'b1;
          end
          sel_lex_pkg::S_BIN_START: begin
            if (c == "0" || c == "1") state_next = sel_lex_pkg::S_BIN; else failed = 1'b1;
          end
          sel_lex_pkg::S_BIN: begin
            if (lc == "l") close_with = 1'b1;
            else if (!(c == "0" || c == "1" || c == "_")) close_wo = 1'b1;
          end
          sel_lex_pkg::S_OCT: begin
            if (lc == "l") close_with = 1'b1;
            else if (!((c inside {["0":"7"]}) || c == "_")) close_wo = 1'b1;
          end
          sel_lex_pkg::S_DIGIT: begin
            if (lc == "l") close_with = 1'b1;
            else if (fd) begin close_with = 1'b1; ck = sel_lex_pkg::K_APPROX; end
            else if (q_item.is_digit || c == "_") ;
            else if (c == ".") state_next = sel_lex_pkg::S_DEC;
            else if (lc == "e") state_next = sel_lex_pkg::S_EXP_SIGN;
            else close_wo = 1'b1;
          end
          sel_lex_pkg::S_DEC_START: begin
            if (q_item.is_digit) state_next = sel_lex_pkg::S_DEC; else failed = 1'b1;
          end
          sel_lex_pkg::S_DEC: begin
            ck = sel_lex_pkg::K_APPROX;
            if (q_item.is_digit || c == "_") ;
            else if (lc == "e") state_next = sel_lex_pkg::S_EXP_SIGN;
            else if (fd) close_with = 1'b1;
            else close_wo = 1'b1;
          end
          sel_lex_pkg::S_EXP_SIGN: begin
            if (c == "+" || c == "-") state_next = sel_lex_pkg::S_EXP_START;
            else if (q_item.is_digit) state_next = sel_lex_pkg::S_EXP;
            else failed = 1'b1;
          end
          sel_lex_pkg::S_EXP_START: begin
            if (q_item.is_digit) state_next = sel_lex_pkg::S_EXP; else failed = 1'b1;
          end
          sel_lex_pkg::S_EXP: begin
            ck = sel_lex_pkg::K_APPROX;
            if (!q_item.is_digit) begin
              if (fd) close_with = 1'b1; else close_wo = 1'b1;
            end
          end
          default: begin
            state_next = sel_lex_pkg::S_START;
            restart = 1'b1;
          end
        endcase
      end

      if (close_with) begin
        state_next = sel_lex_pkg::S_START;
        n_tok = 2'd1;
        t0 = '{kind: ck, offset: 16'(token_begin), length: 16'(span + 1'b1)};
      end else if (failed) begin
        state_next = sel_lex_pkg::S_ERROR;
        n_tok = 2'd1;
        t0 = '{kind: sel_lex_pkg::K_ERROR, offset: 16'(token_begin),
               length: 16'(span + 1'b1)};
      end else if (close_wo) begin
        state_next = sel_lex_pkg::S_START;
        n_tok = 2'd1;
        t0 = '{kind: ck, offset: 16'(token_begin), length: 16'(span)};
        restart = 1'b1;
      end

      // Start-of-token handling, possibly right after closing one. K_END in
      // t1.kind marks a character that is not a one-character operator.
      if (restart && !q_item.is_space) begin
        t1 = '{kind: sel_lex_pkg::K_END, offset: 16'(p), length: 16'd1};
        case (c)
          "(": t1.kind = sel_lex_pkg::K_LPAREN;
          ")": t1.kind = sel_lex_pkg::K_RPAREN;
          ",": t1.kind = sel_lex_pkg::K_COMMA;
          "+": t1.kind = sel_lex_pkg::K_PLUS;
          "-": t1.kind = sel_lex_pkg::K_MINUS;
          "*": t1.kind = sel_lex_pkg::K_STAR;
          "/": t1.kind = sel_lex_pkg::K_SLASH;
          "=": t1.kind = sel_lex_pkg::K_EQUAL;
          default: t1.kind = sel_lex_pkg::K_END;
        endcase
        if (t1.kind == sel_lex_pkg::K_END) begin
          token_begin_next = p;
          if (c == "<") state_next = sel_lex_pkg::S_LT;
          else if (c == ">") state_next = sel_lex_pkg::S_GT;
          else if (q_item.is_alpha || c == "_" || c == "$") begin
            wb_we0 = 1'b1;
            word_too_long_next = 1'b0;
            state_next = sel_lex_pkg::S_IDENT;
          end else if (c == 8'h27 || c == 8'h22) begin
            quote_is_double_next = (c == 8'h22);
            pending_kind_next = (c == 8'h22) ? sel_lex_pkg::K_IDENT : sel_lex_pkg::K_STRING;
            state_next = sel_lex_pkg::S_QUOTED;
          end else if (c == "0") state_next = sel_lex_pkg::S_ZERO;
          else if (q_item.is_digit) state_next = sel_lex_pkg::S_DIGIT;
          else if (c == ".") state_next = sel_lex_pkg::S_DEC_START;
          else begin
            t1.kind = sel_lex_pkg::K_ERROR;
            state_next = sel_lex_pkg::S_ERROR;
          end
        end
        if (t1.kind != sel_lex_pkg::K_END) begin
          if (n_tok == 2'd0) begin
            t0 = t1;
            n_tok = 2'd1;
          end else begin
            n_tok = 2'd2;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && !q_item.end_of_text) begin
      if (wb_we0) word_buffer[0] <= c;
      else if (wb_we) word_buffer[wb_idx] <= c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= sel_lex_pkg::S_START;
      char_position   <= '0;
      token_begin     <= '0;
      pending_kind    <= '0;
      word_too_long   <= 1'b0;
      quote_is_double <= 1'b0;
    end else if (step) begin
      state           <= state_next;
      char_position   <= char_position_next;
      token_begin     <= token_begin_next;
      pending_kind    <= pending_kind_next;
      word_too_long   <= word_too_long_next;
      quote_is_double <= quote_is_double_next;
    end
  end

  // buf0 is the head; buf1_last marks buf1 as the final token of its step.
  logic head_last;
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_cnt <= 2'd0;
    end else begin
      if (step) begin
        if (n_tok == 2'd0) begin
          if (out_valid && out_ready) buf_cnt <= buf_cnt - 1'b1;
        end else begin
          buf_cnt <= n_tok;
        end
      end else if (out_valid && out_ready) begin
        buf_cnt <= buf_cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && n_tok != 2'd0) begin
      buf0      <= t0;
      buf1      <= t1;
      head_last <= (n_tok == 2'd1);
    end else if (out_valid && out_ready && buf_cnt == 2'd2) begin
      buf0      <= buf1;
      head_last <= 1'b1;
    end
  end
  assign buf1_last = 1'b1;

  assign out_valid    = (buf_cnt != 2'd0);
  assign token_kind   = buf0.kind;
  assign token_offset = buf0.offset;
  assign token_length = buf0.length;
  assign last_of_run  = head_last && buf1_last;

endmodule
`default_nettype wire

>>> design/selector_expression_lexer.sv
// Top level of the selector expression lexer.
//
// Input stream: one transaction per character. s_axis_tdata holds char_code,
// s_axis_tuser holds end_of_text (1 = no character, the text has ended).
// Output stream: one transaction per token. m_axis_tdata packs token_kind,
// token_offset and token_length; m_axis_tlast marks the last token caused by
// one input transaction. A character causes zero, one or two tokens; the end
// marker causes the pending token, if any, and then the end token.
// Throughput is one character per cycle while each character yields at most
// one token and the receiver takes each token; a character that yields two
// tokens holds the core while the two-entry token buffer drains. An accepted
// character passes through the classification queue, then the lexer state
// register and token buffer, before its first token appears.
// A four-entry queue separates the character classifier from the lexer core,
// so input keeps flowing briefly while the receiver stalls; once it fills,
// s_axis_tready drops. Reset (rst, synchronous) empties the queue and the
// token buffer and returns the lexer to its start state at position zero.
`timescale 1ns / 1ps
`default_nettype none
module selector_expression_lexer #(
  parameter int PositionBits = sel_lex_pkg::PositionBitsDefault,
  parameter int KeywordChars = sel_lex_pkg::KeywordCharsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] char_code
  input  wire logic        s_axis_tuser,  // [0] end_of_text
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // [4:0] kind, [20:5] offset, [36:21] length
  output logic             m_axis_tlast
);

  logic                    q_valid;
  logic                    q_ready;
  sel_lex_pkg::char_item_t q_item;
  logic [4:0]              token_kind;
  logic [15:0]             token_offset;
  logic [15:0]             token_length;

  sel_lex_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .char_code   (s_axis_tdata),
    .end_of_text (s_axis_tuser),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_item      (q_item)
  );

  sel_lex_core #(
    .PositionBits (PositionBits),
    .KeywordChars (KeywordChars)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_item       (q_item),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .token_kind   (token_kind),
    .token_offset (token_offset),
    .token_length (token_length),
    .last_of_run  (m_axis_tlast)
  );

  assign m_axis_tdata = {3'd0, token_length, token_offset, token_kind};

endmodule
`default_nettype wire
